FILE: rtl/ilist_pkg.sv
// Package for the positional list: sizes, operation and status codes,
// the transfer payload structs and the per-cell command struct.
// Has no dependencies; every other file in rtl uses it by scoped names.
package ilist_pkg;

  // Number of cells in the row.
  localparam int DEPTH = 64;

  // Widths fixed by the transfer fields.
  localparam int KIND_W = 2;
  localparam int IDX_W  = 8;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  // Widths that follow from the depth.
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic        [KIND_W-1:0] kind;
    logic        [IDX_W-1:0]  index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic        [STAT_W-1:0] status;
    logic        [LEN_W-1:0]  length;
  } out_item_t;

  // Command broadcast to every cell in the row. Insert and delete are
  // only raised for operations that succeed.
  typedef struct packed {
    logic              rd;
    logic              ins;
    logic              del;
    logic [CMP_W-1:0]  idx;
    logic [DATA_W-1:0] val;
  } cell_cmd_t;

endpackage

FILE: rtl/indexed_list_insert_delete_top.sv
// Top level of the positional list: handshakes, status decode, length
// counter and the result register around the row of cells.
// Depends on ilist_pkg and ilist_row.
//
//   Channel   Direction  Handshake                 Payload
//   --------  ---------  ------------------------  --------------------------
//   in        input      in_valid_i / in_stall_o   in_item_i  (kind, index, value)
//   out       output     out_valid_o / out_stall_i out_item_o (read_data, status,
//                                                  length)
//
// Every operation, including a shift of the whole list on insert or delete,
// completes in the cycle it is accepted, so one item can be taken each cycle
// while no result is stalled. The result is captured in an output register.
// The input stalls only while that register holds a result that is stalled.
// Reset clears the length counter and the output valid flag; the cells are
// not cleared, since no entry at or above the length is ever read.
module indexed_list_insert_delete_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ilist_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ilist_pkg::out_item_t out_item_o
);

  logic                             out_valid_q, out_valid_d;
  ilist_pkg::out_item_t             out_item_q, out_item_d;
  logic [ilist_pkg::CNT_W-1:0]      count_q, count_d;
  logic                             in_acc;
  logic [ilist_pkg::CMP_W-1:0]      idx_ext, cnt_ext;
  logic                             in_range, ins_range, full;
  ilist_pkg::status_e               status;
  logic                             do_ins, do_del, rd_ok;
  ilist_pkg::cell_cmd_t             cmd;
  logic [ilist_pkg::DATA_W-1:0]     row_rd;

  // The input is held off only while a finished result is waiting on a stall.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign idx_ext   = ilist_pkg::CMP_W'(in_item_i.index);
  assign cnt_ext   = ilist_pkg::CMP_W'(count_q);
  assign in_range  = idx_ext < cnt_ext;
  assign ins_range = idx_ext <= cnt_ext;
  assign full      = count_q == ilist_pkg::CNT_W'(ilist_pkg::DEPTH);

  // Status decode. An insert beyond the end is a range error even when the
  // list is full; the full check comes second.
  always_comb begin
    status = ilist_pkg::ST_RANGE;
    do_ins = 1'b0;
    do_del = 1'b0;
    rd_ok  = 1'b0;
    unique case (ilist_pkg::kind_e'(in_item_i.kind))
      ilist_pkg::KIND_READ: begin
        if (in_range) begin
          status = ilist_pkg::ST_OK;
          rd_ok  = 1'b1;
        end
      end
      ilist_pkg::KIND_INSERT: begin
        if (!ins_range) begin
          status = ilist_pkg::ST_RANGE;
        end else if (full) begin
          status = ilist_pkg::ST_FULL;
        end else begin
          status = ilist_pkg::ST_OK;
          do_ins = 1'b1;
        end
      end
      ilist_pkg::KIND_DELETE: begin
        if (in_range) begin
          status = ilist_pkg::ST_OK;
          do_del = 1'b1;
        end
      end
      default: begin
        status = ilist_pkg::ST_RANGE;
      end
    endcase
  end

  // The row only moves data on a successful insert or delete that is
  // actually transferred in.
  assign cmd.rd  = rd_ok;
  assign cmd.ins = in_acc && do_ins;
  assign cmd.del = in_acc && do_del;
  assign cmd.idx = idx_ext;
  assign cmd.val = ilist_pkg::DATA_W'(in_item_i.value);

  ilist_row u_row (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .rd_data_o (row_rd)
  );

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + ilist_pkg::CNT_W'(1);
    end else if (cmd.del) begin
      count_d = count_q - ilist_pkg::CNT_W'(1);
    end
  end

  // Result register: loaded on every transfer in, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (in_acc) begin
      out_valid_d          = 1'b1;
      out_item_d.read_data = rd_ok ? row_rd : '0;
      out_item_d.status    = status;
      out_item_d.length    = ilist_pkg::LEN_W'(count_d);
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The length never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ilist_pkg::CNT_W'(ilist_pkg::DEPTH))
    else $error("list length exceeds the number of cells");

  // Without a transfer in, the length holds.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(count_q))
    else $error("list length changed without a transfer");

  // A full status is only reported while the list is at capacity.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status == ilist_pkg::ST_FULL)
      |-> count_q == ilist_pkg::CNT_W'(ilist_pkg::DEPTH))
    else $error("full status reported with room in the list");

  // A failed operation returns zero read data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status != ilist_pkg::ST_OK)
      |-> out_item_q.read_data == '0)
    else $error("nonzero read data on a failed operation");

endmodule

FILE: rtl/ilist_cell.sv
// One storage cell of the positional list. Holds a single entry and moves
// it to or from its neighbors on insert and delete.
// Depends on ilist_pkg.
module ilist_cell (
  input  logic                         clk_i,
  input  ilist_pkg::cell_cmd_t         cmd_i,
  input  logic [ilist_pkg::POS_W-1:0]  pos_i,
  input  logic [ilist_pkg::DATA_W-1:0] left_i,
  input  logic [ilist_pkg::DATA_W-1:0] right_i,
  output logic [ilist_pkg::DATA_W-1:0] data_o,
  output logic [ilist_pkg::DATA_W-1:0] rd_o
);

  logic [ilist_pkg::DATA_W-1:0] data_q, data_d;
  logic [ilist_pkg::CMP_W-1:0]  pos_ext;
  logic                         hit, above;

  assign pos_ext = ilist_pkg::CMP_W'(pos_i);
  assign hit     = (pos_ext == cmd_i.idx);
  assign above   = (pos_ext > cmd_i.idx);

  // Cells past the insert point take their left neighbor; cells at or past
  // the delete point take their right neighbor.
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (above) begin
        data_d = left_i;
      end else if (hit) begin
        data_d = cmd_i.val;
      end
    end else if (cmd_i.del) begin
      if (above || hit) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins || cmd_i.del) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  assign rd_o   = (cmd_i.rd && hit) ? data_q : '0;

endmodule

FILE: rtl/ilist_row.sv
// Row of list cells chained to their neighbors, with the OR network that
// collects the addressed entry on a read.
// Depends on ilist_pkg and ilist_cell.
module ilist_row (
  input  logic                         clk_i,
  input  ilist_pkg::cell_cmd_t         cmd_i,
  output logic [ilist_pkg::DATA_W-1:0] rd_data_o
);

  logic [ilist_pkg::DATA_W-1:0] cell_data [ilist_pkg::DEPTH];
  logic [ilist_pkg::DATA_W-1:0] cell_rd   [ilist_pkg::DEPTH];

  for (genvar g = 0; g < ilist_pkg::DEPTH; g++) begin : g_cell
    logic [ilist_pkg::DATA_W-1:0] left_w, right_w;

    if (g == 0) begin : g_first
      assign left_w = cell_data[g];
    end else begin : g_inner_l
      assign left_w = cell_data[g-1];
    end

    if (g == ilist_pkg::DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_inner_r
      assign right_w = cell_data[g+1];
    end

    ilist_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_i),
      .pos_i   (ilist_pkg::POS_W'(g)),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // At most one cell drives a nonzero word, so an OR collects it.
  always_comb begin
    rd_data_o = '0;
    for (int i = 0; i < ilist_pkg::DEPTH; i++) begin
      rd_data_o = rd_data_o | cell_rd[i];
    end
  end

endmodule
